FILE: design/psa_pkg.sv
package psa_pkg;

  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int unsigned MAX_LEN       = 512;
  localparam int unsigned STACK_DEPTH   = 1024;
  localparam int unsigned TRAILER_BYTES = 4;

  localparam int unsigned LEN_W    = 10;
  localparam int unsigned PC_W     = 5;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned ADDR_W   = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned USED_W   = PC_W + PAGE_SHIFT;
  localparam int unsigned SUM_W    = USED_W + 1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LEN_TOO_BIG = 2'd1,
    ST_NO_MEMORY   = 2'd2,
    ST_STACK_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

endpackage

FILE: design/psa_ram.sv
module psa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/paged_stack_allocator_unit.sv
// LIFO allocator over a region that grows and shrinks in whole pages.
// Input channel: in_valid_i / in_stall_o with req_type_i (0 alloc, 1 free)
// and length_i. Output channel: out_valid_o / out_stall_i with status_o,
// block_offset_o, freed_length_o and pages_held_o, one result per request.
// A request is decided in the cycle it is accepted; its result is held in
// the output register from the next cycle, and a new request can be taken
// every cycle unless a stalled result blocks input (throughput 1 per cycle).
// The top of the length stack sits in a register; the stack memory keeps a
// registered read of the entry below it, so a free never waits on the RAM.
// The user writes max_pages through max_pages_we_i / max_pages_i only while
// idle; the block does not check this. Reset clears used bytes, page count
// and stack count, sets max_pages to 16 and empties the output register;
// the stack memory is not cleared. While a result waits and out_stall_i is
// high, in_stall_o is high and no request is taken; the result is held.
module paged_stack_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        max_pages_we_i,
  input  logic [psa_pkg::PC_W-1:0]    max_pages_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [psa_pkg::LEN_W-1:0]   length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [psa_pkg::OFFSET_W-1:0] block_offset_o,
  output logic [psa_pkg::LEN_W-1:0]   freed_length_o,
  output logic [psa_pkg::PC_W-1:0]    pages_held_o
);

  localparam int unsigned SUM_W = psa_pkg::SUM_W;

  logic [psa_pkg::PC_W-1:0]     max_pages_q;
  logic [psa_pkg::USED_W-1:0]   used_q, used_d;
  logic [psa_pkg::PC_W-1:0]     pc_q, pc_d;
  logic [psa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [psa_pkg::LEN_W-1:0]    top_q, top_d;
  logic                         out_valid_q;
  psa_pkg::status_e             status_q, status_d;
  logic [psa_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [psa_pkg::LEN_W-1:0]    freed_q, freed_d;

  logic                         accept;
  logic                         push;
  logic [psa_pkg::LEN_W-1:0]    below_data;
  logic [psa_pkg::CNT_W-1:0]    raddr_full;
  logic [psa_pkg::PC_W-1:0]     pc_eff;
  logic [SUM_W-1:0]             cap_eff, cap_cur, need, sub;
  logic [psa_pkg::USED_W-1:0]   used_free;
  logic                         release_page;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign pc_eff    = (pc_q == '0) ? psa_pkg::PC_W'(1) : pc_q;
  assign cap_eff   = SUM_W'(pc_eff) << psa_pkg::PAGE_SHIFT;
  assign cap_cur   = SUM_W'(pc_q) << psa_pkg::PAGE_SHIFT;
  assign need      = SUM_W'(used_q) + SUM_W'(length_i) + SUM_W'(psa_pkg::TRAILER_BYTES);
  assign sub       = SUM_W'(top_q) + SUM_W'(psa_pkg::TRAILER_BYTES);
  assign used_free = (sub > SUM_W'(used_q)) ? '0 : psa_pkg::USED_W'(SUM_W'(used_q) - sub);
  assign release_page = (cap_cur > SUM_W'(used_free) + SUM_W'(psa_pkg::PAGE_BYTES))
                        && (pc_q > psa_pkg::PC_W'(1));

  always_comb begin
    used_d   = used_q;
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    push     = 1'b0;
    status_d = status_q;
    offset_d = offset_q;
    freed_d  = freed_q;
    if (accept) begin
      status_d = psa_pkg::ST_OK;
      offset_d = '0;
      freed_d  = '0;
      unique case (psa_pkg::req_e'(req_type_i))
        psa_pkg::REQ_ALLOC: begin
          priority if (length_i > psa_pkg::LEN_W'(psa_pkg::MAX_LEN)) begin
            status_d = psa_pkg::ST_LEN_TOO_BIG;
          end else if (pc_q == '0 && max_pages_q == '0) begin
            status_d = psa_pkg::ST_NO_MEMORY;
          end else if (cnt_q == psa_pkg::CNT_W'(psa_pkg::STACK_DEPTH)) begin
            status_d = psa_pkg::ST_NO_MEMORY;
            pc_d     = pc_eff;
          end else if (need > cap_eff
                       && {1'b0, pc_eff} + 6'd1 > {1'b0, max_pages_q}) begin
            status_d = psa_pkg::ST_NO_MEMORY;
            pc_d     = pc_eff;
          end else begin
            pc_d     = (need > cap_eff) ? pc_eff + psa_pkg::PC_W'(1) : pc_eff;
            offset_d = used_q[psa_pkg::OFFSET_W-1:0];
            used_d   = psa_pkg::USED_W'(need);
            cnt_d    = cnt_q + psa_pkg::CNT_W'(1);
            top_d    = length_i;
            push     = 1'b1;
          end
        end
        psa_pkg::REQ_FREE: begin
          if (cnt_q == '0) begin
            status_d = psa_pkg::ST_STACK_EMPTY;
          end else begin
            freed_d = top_q;
            used_d  = used_free;
            cnt_d   = cnt_q - psa_pkg::CNT_W'(1);
            top_d   = below_data;
            if (release_page) begin
              pc_d = pc_q - psa_pkg::PC_W'(1);
            end
          end
        end
        default: begin
          status_d = status_q;
        end
      endcase
    end
  end

  // read the entry below the next top so a pop finds it ready
  assign raddr_full = cnt_d - psa_pkg::CNT_W'(2);

  psa_ram #(
    .WIDTH(psa_pkg::LEN_W),
    .DEPTH(psa_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(cnt_q[psa_pkg::ADDR_W-1:0]),
    .wdata_i(length_i),
    .raddr_i(raddr_full[psa_pkg::ADDR_W-1:0]),
    .rdata_o(below_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pages_q <= psa_pkg::PC_W'(16);
      used_q      <= '0;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (max_pages_we_i) begin
        max_pages_q <= max_pages_i;
      end
      used_q <= used_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    status_q <= status_d;
    offset_q <= offset_d;
    freed_q  <= freed_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = offset_q;
  assign freed_length_o = freed_q;
  assign pages_held_o   = pc_q;

endmodule

FILE: design/psa_checker.sv
module psa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         max_pages_we_i,
  input logic [psa_pkg::PC_W-1:0]     max_pages_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         req_type_i,
  input logic [psa_pkg::LEN_W-1:0]    length_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   status_o,
  input logic [psa_pkg::OFFSET_W-1:0] block_offset_o,
  input logic [psa_pkg::LEN_W-1:0]    freed_length_o,
  input logic [psa_pkg::PC_W-1:0]     pages_held_o
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(block_offset_o) && $stable(freed_length_o))
    else $error("stalled result changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != psa_pkg::ST_OK |->
      block_offset_o == '0 && freed_length_o == '0)
    else $error("error result carries offset or length");

  a_ok_holds_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == psa_pkg::ST_OK |-> pages_held_o != '0)
    else $error("successful transaction with no page held");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

bind paged_stack_allocator_unit psa_checker u_psa_checker (.*);

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 300000;
  localparam int unsigned LEN_MAX   = (1 << psa_pkg::LEN_W) - 1;

  typedef struct {
    psa_pkg::status_e             status;
    logic [psa_pkg::OFFSET_W-1:0] offset;
    logic [psa_pkg::LEN_W-1:0]    freed;
    logic [psa_pkg::PC_W-1:0]     pages;
  } reply_t;

  class alloc_tracker;
    int unsigned max_pages;
    int unsigned used;
    int unsigned pages;
    int unsigned depth;
    int unsigned lens [psa_pkg::STACK_DEPTH];
    int unsigned peak_depth;
    int unsigned accepted;
    int unsigned checked;
    int unsigned mismatches;
    reply_t      replies_due [$];

    function new();
      max_pages  = 16;
      used       = 0;
      pages      = 0;
      depth      = 0;
      peak_depth = 0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_max_pages(int unsigned v);
      max_pages = v;
    endfunction

    function reply_t predict_reply(psa_pkg::req_e kind, logic [psa_pkg::LEN_W-1:0] len);
      reply_t      r;
      int unsigned n;
      bit          ok;
      r.status = psa_pkg::ST_OK;
      r.offset = '0;
      r.freed  = '0;
      n        = 32'(len);
      if (kind == psa_pkg::REQ_ALLOC) begin
        ok = 1'b1;
        if (n > psa_pkg::MAX_LEN) begin
          r.status = psa_pkg::ST_LEN_TOO_BIG;
          ok       = 1'b0;
        end else if (pages == 0) begin
          if (max_pages == 0) begin
            r.status = psa_pkg::ST_NO_MEMORY;
            ok       = 1'b0;
          end else begin
            pages = 1;
          end
        end
        if (ok && depth == psa_pkg::STACK_DEPTH) begin
          r.status = psa_pkg::ST_NO_MEMORY;
          ok       = 1'b0;
        end
        if (ok && used + n + psa_pkg::TRAILER_BYTES > pages * psa_pkg::PAGE_BYTES) begin
          if (pages + 1 > max_pages) begin
            r.status = psa_pkg::ST_NO_MEMORY;
            ok       = 1'b0;
          end else begin
            pages++;
          end
        end
        if (ok) begin
          r.offset    = used[psa_pkg::OFFSET_W-1:0];
          lens[depth] = n;
          depth++;
          used += n + psa_pkg::TRAILER_BYTES;
          if (depth > peak_depth) peak_depth = depth;
        end
      end else if (depth == 0) begin
        r.status = psa_pkg::ST_STACK_EMPTY;
      end else begin
        depth--;
        n = lens[depth];
        if (n + psa_pkg::TRAILER_BYTES > used) used = 0;
        else used -= n + psa_pkg::TRAILER_BYTES;
        if (pages * psa_pkg::PAGE_BYTES - used > psa_pkg::PAGE_BYTES && pages > 1) pages--;
        r.freed = n[psa_pkg::LEN_W-1:0];
      end
      r.pages = pages[psa_pkg::PC_W-1:0];
      return r;
    endfunction

    function void note_request(psa_pkg::req_e kind, logic [psa_pkg::LEN_W-1:0] len);
      replies_due.push_back(predict_reply(kind, len));
      accepted++;
    endfunction

    function void check_reply(logic [1:0] st, logic [psa_pkg::OFFSET_W-1:0] off,
                              logic [psa_pkg::LEN_W-1:0] fl, logic [psa_pkg::PC_W-1:0] pg);
      reply_t e;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: status=%0d offset=%0d freed=%0d pages=%0d",
                   $time, st, off, fl, pg);
        return;
      end
      e = replies_due.pop_front();
      checked++;
      if (st !== e.status || off !== e.offset || fl !== e.freed || pg !== e.pages) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp status=%0d offset=%0d freed=%0d pages=%0d",
                   $time, e.status, e.offset, e.freed, e.pages);
          $display("%0t:          got status=%0d offset=%0d freed=%0d pages=%0d",
                   $time, st, off, fl, pg);
        end
      end
    endfunction
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         max_pages_we_i = 1'b0;
  logic [psa_pkg::PC_W-1:0]     max_pages_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic                         req_type_i     = 1'b0;
  logic [psa_pkg::LEN_W-1:0]    length_i       = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic [1:0]                   status_o;
  logic [psa_pkg::OFFSET_W-1:0] block_offset_o;
  logic [psa_pkg::LEN_W-1:0]    freed_length_o;
  logic [psa_pkg::PC_W-1:0]     pages_held_o;

  alloc_tracker tracker;
  bit           gaps_on  = 1'b0;
  bit           stall_on = 1'b0;
  int unsigned  hold_len = 0;
  int unsigned  cycles   = 0;

  paged_stack_allocator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_pages_we_i (max_pages_we_i),
    .max_pages_i    (max_pages_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .length_i       (length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .block_offset_o (block_offset_o),
    .freed_length_o (freed_length_o),
    .pages_held_o   (pages_held_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("FAIL paged_stack_allocator_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_reply(status_o, block_offset_o, freed_length_o, pages_held_o);
  end

  // result side: long hold-off on request, otherwise short random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_req(psa_pkg::req_e kind, logic [psa_pkg::LEN_W-1:0] len);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    length_i   <= len;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(kind, len);
  endtask

  // drop valid and wait for every pending result
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.replies_due.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_max_pages(logic [psa_pkg::PC_W-1:0] v);
    max_pages_we_i <= 1'b1;
    max_pages_i    <= v;
    @(posedge clk_i);
    max_pages_we_i <= 1'b0;
    tracker.set_max_pages(32'(v));
  endtask

  task automatic random_req(int unsigned alloc_pct, int unsigned min_len);
    logic [psa_pkg::LEN_W-1:0] len;
    int unsigned               pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = psa_pkg::LEN_W'($urandom_range(psa_pkg::MAX_LEN + 1, LEN_MAX));
    else if (pick == 1) len = '0;
    else if (pick == 2) len = psa_pkg::LEN_W'(psa_pkg::MAX_LEN);
    else len = psa_pkg::LEN_W'($urandom_range(min_len, psa_pkg::MAX_LEN));
    if ($urandom_range(1, 100) <= alloc_pct) send_req(psa_pkg::REQ_ALLOC, len);
    else send_req(psa_pkg::REQ_FREE, len);
  endtask

  task automatic run_phase(logic [psa_pkg::PC_W-1:0] cap, int unsigned count,
                           int unsigned alloc_pct, int unsigned min_len, bit swing);
    int unsigned pct;
    settle();
    write_max_pages(cap);
    for (int unsigned i = 0; i < count; i++) begin
      pct = (swing && (i / 20) % 2 == 1) ? 100 - alloc_pct : alloc_pct;
      random_req(pct, min_len);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no page may be claimed at all
    write_max_pages('0);
    send_req(psa_pkg::REQ_ALLOC, 10'd5);
    send_req(psa_pkg::REQ_FREE, psa_pkg::LEN_W'(LEN_MAX));
    send_req(psa_pkg::REQ_ALLOC, psa_pkg::LEN_W'(LEN_MAX));
    settle();

    // single page: growth is refused
    write_max_pages(5'd1);
    send_req(psa_pkg::REQ_ALLOC, '0);
    repeat (8) send_req(psa_pkg::REQ_ALLOC, psa_pkg::LEN_W'(psa_pkg::MAX_LEN));
    send_req(psa_pkg::REQ_FREE, '0);
    send_req(psa_pkg::REQ_FREE, '0);
    send_req(psa_pkg::REQ_ALLOC, psa_pkg::LEN_W'(psa_pkg::MAX_LEN + 1));
    settle();

    write_max_pages(5'd16);
    repeat (7) send_req(psa_pkg::REQ_FREE, 10'h2AA);
    send_req(psa_pkg::REQ_ALLOC, 10'h155);
    send_req(psa_pkg::REQ_ALLOC, 10'h2AA);

    gaps_on  = 1'b1;
    stall_on = 1'b1;
    settle();
    hold_len = 40;
    run_phase(5'd16, 40, 60, 0, 1'b1);
    run_phase(5'd1, 30, 50, 0, 1'b1);
    run_phase(5'd31, 240, 90, 384, 1'b0);
    run_phase(5'd8, 30, 40, 0, 1'b1);
    run_phase(psa_pkg::PC_W'($urandom_range(2, 15)), 30, 50, 0, 1'b1);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(5'd16, 30, 50, 0, 1'b1);
    settle();
    repeat (4) @(posedge clk_i);

    $display("%0d requests accepted, %0d results checked, %0d mismatches",
             tracker.accepted, tracker.checked, tracker.mismatches);
    $display("page limits 0, 1, 8, 16, 31 and one random; stack depth reached %0d",
             tracker.peak_depth);
    if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
      $display("PASS paged_stack_allocator_unit");
    end else begin
      $display("FAIL paged_stack_allocator_unit");
    end
    $finish;
  end

endmodule
